FILE: design/uvwc_pkg.sv
`default_nettype none

package uvwc_pkg;

    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned ACC_W       = 68;

    localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

    localparam logic [CFG_INDEX_W-1:0] REG_VEHICLE_MASS      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUOYANCY_FORCE    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_CENTRE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUOYANCY_CENTRE   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIN_DRAG_TRANS    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIN_DRAG_ROT      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_QUAD_DRAG_TRANS   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_QUAD_DRAG_ROT     = 4'd7;

    typedef struct packed {
        logic [31:0] vehicle_mass;
        logic [31:0] buoyancy_force;
        logic [47:0] gravity_centre;
        logic [47:0] buoyancy_centre;
        logic [47:0] linear_drag_translation;
        logic [47:0] linear_drag_rotation;
        logic [47:0] quadratic_drag_translation;
        logic [47:0] quadratic_drag_rotation;
    } t_cfg;

    typedef struct packed {
        logic [31:0] force_in_x;
        logic [31:0] force_in_y;
        logic [31:0] force_in_z;
        logic [31:0] torque_in_x;
        logic [31:0] torque_in_y;
        logic [31:0] torque_in_z;
        logic [63:0] attitude;
        logic [47:0] linear_velocity;
        logic [47:0] angular_velocity;
        logic [47:0] water_current;
    } t_in;

    typedef struct packed {
        logic [31:0] force_out_x;
        logic [31:0] force_out_y;
        logic [31:0] force_out_z;
        logic [31:0] torque_out_x;
        logic [31:0] torque_out_y;
        logic [31:0] torque_out_z;
    } t_out;

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [31:0] res;
        if (v > $signed(68'sh0_0000_0000_7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -$signed(68'sh0_0000_0000_8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/uvwc_cfg_regs.sv
`default_nettype none

module uvwc_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [uvwc_pkg::CFG_INDEX_W-1:0]   i_index,
    input  wire logic [uvwc_pkg::CFG_DATA_W-1:0]    i_data,
    output uvwc_pkg::t_cfg                          o_cfg
);

    uvwc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_we) begin
            unique case (i_index)
                uvwc_pkg::REG_VEHICLE_MASS:    r_cfg.vehicle_mass <= i_data[31:0];
                uvwc_pkg::REG_BUOYANCY_FORCE:  r_cfg.buoyancy_force <= i_data[31:0];
                uvwc_pkg::REG_GRAVITY_CENTRE:  r_cfg.gravity_centre <= i_data;
                uvwc_pkg::REG_BUOYANCY_CENTRE: r_cfg.buoyancy_centre <= i_data;
                uvwc_pkg::REG_LIN_DRAG_TRANS:  r_cfg.linear_drag_translation <= i_data;
                uvwc_pkg::REG_LIN_DRAG_ROT:    r_cfg.linear_drag_rotation <= i_data;
                uvwc_pkg::REG_QUAD_DRAG_TRANS: r_cfg.quadratic_drag_translation <= i_data;
                uvwc_pkg::REG_QUAD_DRAG_ROT:   r_cfg.quadratic_drag_rotation <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/underwater_vehicle_wrench_compensation.sv
// Channel   | Handshake                       | Payload
// command   | start in, busy out              | i_in  (uvwc_pkg::t_in)
// result    | o_valid strobe, one cycle       | o_out (uvwc_pkg::t_out)
// config    | i_cfg_valid in, o_cfg_ready out | i_cfg_index, i_cfg_data
//
// A beat enters every cycle; busy is never raised. Each result leaves through a
// six-stage pipeline set by the multiplier chain.
// Reset is synchronous and clears the valid bits and the configuration registers.
// The result strobe cannot be stalled, so the pipeline never holds.
`default_nettype none

module underwater_vehicle_wrench_compensation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire uvwc_pkg::t_in                     i_in,
    output logic                                   o_valid,
    output uvwc_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [uvwc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [uvwc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    uvwc_pkg::t_cfg cfg;

    uvwc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    // Stage 1: rotation matrix and weight.
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
    logic signed [33:0] r28 [9];
    logic        [51:0] w_prod;
    logic        [35:0] w_q;
    logic signed [19:0] r_rm [9];
    logic signed [36:0] r_g;
    uvwc_pkg::t_in      r_in1;

    localparam logic signed [33:0] ONE28 = 34'sd268435456;

    always_comb begin
        qw = $signed(i_in.attitude[15:0]);
        qx = $signed(i_in.attitude[31:16]);
        qy = $signed(i_in.attitude[47:32]);
        qz = $signed(i_in.attitude[63:48]);
        p_xx = qx * qx;
        p_yy = qy * qy;
        p_zz = qz * qz;
        p_xy = qx * qy;
        p_xz = qx * qz;
        p_yz = qy * qz;
        p_wx = qw * qx;
        p_wy = qw * qy;
        p_wz = qw * qz;
        r28[0] = ONE28 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
        r28[1] = (34'(p_xy) - 34'(p_wz)) <<< 1;
        r28[2] = (34'(p_xz) + 34'(p_wy)) <<< 1;
        r28[3] = (34'(p_xy) + 34'(p_wz)) <<< 1;
        r28[4] = ONE28 - ((34'(p_xx) + 34'(p_zz)) <<< 1);
        r28[5] = (34'(p_yz) - 34'(p_wx)) <<< 1;
        r28[6] = (34'(p_xz) - 34'(p_wy)) <<< 1;
        r28[7] = (34'(p_yz) + 34'(p_wx)) <<< 1;
        r28[8] = ONE28 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
        w_prod = 52'(cfg.vehicle_mass) * 52'(uvwc_pkg::GRAVITY_Q16);
        w_q    = 36'((w_prod + 52'd32768) >> 16);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_rm[k] <= 20'((r28[k] + 34'sd8192) >>> 14);
        end
        r_g   <= -$signed({1'b0, w_q});
        r_in1 <= i_in;
    end

    // Stage 2: restoring forces and rotated current products.
    logic signed [56:0] gbp [3];
    logic signed [51:0] bbp [3];
    logic signed [31:0] bz;
    logic signed [42:0] r_gb [3];
    logic signed [37:0] r_bb [3];
    logic signed [35:0] r_cp [9];
    uvwc_pkg::t_in      r_in2;

    always_comb begin
        bz = $signed(cfg.buoyancy_force);
        for (int i = 0; i < 3; i++) begin
            gbp[i] = r_rm[3*i+2] * r_g;
            bbp[i] = r_rm[3*i+2] * bz;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_gb[i] <= 43'((gbp[i] + 57'sd8192) >>> 14);
            r_bb[i] <= 38'((bbp[i] + 52'sd8192) >>> 14);
            for (int j = 0; j < 3; j++) begin
                r_cp[3*i+j] <= 36'(r_rm[3*i+j]
                    * $signed(r_in1.water_current[16*j +: 16]));
            end
        end
        r_in2 <= r_in1;
    end

    // Stage 3: relative velocity, moment products, force after restoring terms.
    logic signed [37:0] acc [3];
    logic signed [24:0] r_vel [6];
    logic signed [58:0] r_mg [3][2];
    logic signed [58:0] r_mb [3][2];
    logic signed [53:0] r_fw3 [6];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = 38'(r_cp[3*i]) + 38'(r_cp[3*i+1]) + 38'(r_cp[3*i+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_vel[i] <= 25'($signed(r_in2.linear_velocity[16*i +: 16]))
                - 25'((acc[i] + 38'sd8192) >>> 14);
            r_vel[i+3] <= 25'($signed(r_in2.angular_velocity[16*i +: 16]));
            r_mg[i][0] <= $signed(cfg.gravity_centre[16*((i == 2) ? 0 : i + 1) +: 16])
                * r_gb[(i == 0) ? 2 : i - 1];
            r_mg[i][1] <= $signed(cfg.gravity_centre[16*((i == 0) ? 2 : i - 1) +: 16])
                * r_gb[(i == 2) ? 0 : i + 1];
            r_mb[i][0] <= $signed(cfg.buoyancy_centre[16*((i == 2) ? 0 : i + 1) +: 16])
                * r_bb[(i == 0) ? 2 : i - 1];
            r_mb[i][1] <= $signed(cfg.buoyancy_centre[16*((i == 0) ? 2 : i - 1) +: 16])
                * r_bb[(i == 2) ? 0 : i + 1];
        end
        r_fw3[0] <= 54'($signed(r_in2.force_in_x)) - 54'(r_gb[0]) - 54'(r_bb[0]);
        r_fw3[1] <= 54'($signed(r_in2.force_in_y)) - 54'(r_gb[1]) - 54'(r_bb[1]);
        r_fw3[2] <= 54'($signed(r_in2.force_in_z)) - 54'(r_gb[2]) - 54'(r_bb[2]);
        r_fw3[3] <= 54'($signed(r_in2.torque_in_x));
        r_fw3[4] <= 54'($signed(r_in2.torque_in_y));
        r_fw3[5] <= 54'($signed(r_in2.torque_in_z));
    end

    // Stage 4: torque after moments, linear drag, velocity magnitude products.
    logic signed [59:0] md_g [3];
    logic signed [59:0] md_b [3];
    logic signed [16:0] kl [6];
    logic signed [16:0] kq [6];
    logic signed [25:0] vabs [6];
    logic signed [53:0] r_fw4 [6];
    logic signed [43:0] r_lin4 [6];
    logic signed [50:0] r_avv [6];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            md_g[i] = 60'(r_mg[i][0]) - 60'(r_mg[i][1]);
            md_b[i] = 60'(r_mb[i][0]) - 60'(r_mb[i][1]);
            kl[i]   = $signed({1'b0, cfg.linear_drag_translation[16*i +: 16]});
            kl[i+3] = $signed({1'b0, cfg.linear_drag_rotation[16*i +: 16]});
            kq[i]   = $signed({1'b0, cfg.quadratic_drag_translation[16*i +: 16]});
            kq[i+3] = $signed({1'b0, cfg.quadratic_drag_rotation[16*i +: 16]});
        end
        for (int k = 0; k < 6; k++) begin
            vabs[k] = r_vel[k][24] ? -26'(r_vel[k]) : 26'(r_vel[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_fw4[i]   <= r_fw3[i];
            r_fw4[i+3] <= r_fw3[i+3]
                - 54'((md_g[i] + 60'sd128) >>> 8)
                - 54'((md_b[i] + 60'sd128) >>> 8);
        end
        for (int k = 0; k < 6; k++) begin
            r_lin4[k] <= 44'(kl[k] * r_vel[k]) <<< 2;
            r_avv[k]  <= vabs[k] * r_vel[k];
        end
    end

    // Stage 5: quadratic drag product.
    logic signed [53:0] r_fw5 [6];
    logic signed [43:0] r_lin5 [6];
    logic signed [67:0] r_qp [6];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_fw5[k]  <= r_fw4[k];
            r_lin5[k] <= r_lin4[k];
            r_qp[k]   <= kq[k] * r_avv[k];
        end
    end

    // Stage 6: final sums and saturation.
    logic signed [uvwc_pkg::ACC_W-1:0] tot [6];
    uvwc_pkg::t_out                    r_out;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            tot[k] = 68'(r_fw5[k]) - 68'(r_lin5[k]) - ((r_qp[k] + 68'sd32) >>> 6);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.force_out_x  <= uvwc_pkg::sat32(tot[0]);
        r_out.force_out_y  <= uvwc_pkg::sat32(tot[1]);
        r_out.force_out_z  <= uvwc_pkg::sat32(tot[2]);
        r_out.torque_out_x <= uvwc_pkg::sat32(tot[3]);
        r_out.torque_out_y <= uvwc_pkg::sat32(tot[4]);
        r_out.torque_out_z <= uvwc_pkg::sat32(tot[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_valid = r_v6;
    assign o_out   = r_out;

endmodule

`default_nettype wire

FILE: verif/underwater_vehicle_wrench_compensation_tb.sv
`timescale 1ns / 1ps

module underwater_vehicle_wrench_compensation_tb;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    uvwc_pkg::t_in                    i_in;
    logic                             o_valid;
    uvwc_pkg::t_out                   o_out;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [uvwc_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [uvwc_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    underwater_vehicle_wrench_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    typedef logic signed [95:0] t_wide;

    uvwc_pkg::t_cfg vehicle_cfg;
    uvwc_pkg::t_out wrench_queue[$];
    int             mismatch_count;
    int             gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("underwater_vehicle_wrench_compensation_tb: FAIL");
        $finish;
    end

    function automatic t_wide lane16(input logic [63:0] v, input int k);
        logic signed [15:0] s;
        s = v[16*k +: 16];
        return t_wide'(s);
    endfunction

    function automatic t_wide round_shift(input t_wide x, input int s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    function automatic logic [31:0] clamp32(input t_wide v);
        logic [31:0] res;
        if (v > t_wide'(64'sh7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -t_wide'(64'sh8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic t_wide axis_drag(input logic [47:0] lin, input logic [47:0] quad,
                                        input int k, input t_wide v);
        t_wide kl, kq, av;
        kl = t_wide'({1'b0, lin[16*k +: 16]});
        kq = t_wide'({1'b0, quad[16*k +: 16]});
        av = (v < 0) ? -v : v;
        return kl * v * 4 + round_shift(kq * (av * v), 6);
    endfunction

    function automatic uvwc_pkg::t_out compensate_wrench(input uvwc_pkg::t_in c);
        t_wide qw, qx, qy, qz, one, g, bz, acc, rel;
        t_wide r28[3][3];
        t_wide rot[3][3];
        t_wide gb[3], bb[3], cg[3], cb[3], cur[3], f[3], t[3];
        logic [31:0] fin[3], tin[3];
        logic [47:0] lv, av;
        int a, b;
        uvwc_pkg::t_out o;
        qw = lane16(c.attitude, 0);
        qx = lane16(c.attitude, 1);
        qy = lane16(c.attitude, 2);
        qz = lane16(c.attitude, 3);
        one = t_wide'(1) <<< 28;
        r28[0][0] = one - 2 * (qy * qy + qz * qz);
        r28[0][1] = 2 * (qx * qy - qw * qz);
        r28[0][2] = 2 * (qx * qz + qw * qy);
        r28[1][0] = 2 * (qx * qy + qw * qz);
        r28[1][1] = one - 2 * (qx * qx + qz * qz);
        r28[1][2] = 2 * (qy * qz - qw * qx);
        r28[2][0] = 2 * (qx * qz - qw * qy);
        r28[2][1] = 2 * (qy * qz + qw * qx);
        r28[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = round_shift(r28[i][j], 14);
        g = -((t_wide'({1'b0, vehicle_cfg.vehicle_mass}) * 642908 + 32768) >>> 16);
        bz = t_wide'($signed(vehicle_cfg.buoyancy_force));
        fin = '{c.force_in_x, c.force_in_y, c.force_in_z};
        tin = '{c.torque_in_x, c.torque_in_y, c.torque_in_z};
        for (int i = 0; i < 3; i++) begin
            gb[i] = round_shift(rot[i][2] * g, 14);
            bb[i] = round_shift(rot[i][2] * bz, 14);
            cg[i] = lane16(64'(vehicle_cfg.gravity_centre), i);
            cb[i] = lane16(64'(vehicle_cfg.buoyancy_centre), i);
            cur[i] = lane16(64'(c.water_current), i);
            f[i] = t_wide'($signed(fin[i])) - gb[i] - bb[i];
            t[i] = t_wide'($signed(tin[i]));
        end
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            t[i] -= round_shift(cg[a] * gb[b] - cg[b] * gb[a], 8);
            t[i] -= round_shift(cb[a] * bb[b] - cb[b] * bb[a], 8);
        end
        lv = c.linear_velocity;
        av = c.angular_velocity;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += rot[i][j] * cur[j];
            rel = lane16(64'(lv), i) - round_shift(acc, 14);
            f[i] -= axis_drag(vehicle_cfg.linear_drag_translation,
                              vehicle_cfg.quadratic_drag_translation, i, rel);
            t[i] -= axis_drag(vehicle_cfg.linear_drag_rotation,
                              vehicle_cfg.quadratic_drag_rotation, i, lane16(64'(av), i));
        end
        o.force_out_x  = clamp32(f[0]);
        o.force_out_y  = clamp32(f[1]);
        o.force_out_z  = clamp32(f[2]);
        o.torque_out_x = clamp32(t[0]);
        o.torque_out_y = clamp32(t[1]);
        o.torque_out_z = clamp32(t[2]);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        uvwc_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (wrench_queue.size() == 0) begin
                report_mismatch("unexpected result force_out_x", o_out.force_out_x, '0);
            end else begin
                want = wrench_queue.pop_front();
                if (o_out.force_out_x !== want.force_out_x)
                    report_mismatch("force_out_x", o_out.force_out_x, want.force_out_x);
                if (o_out.force_out_y !== want.force_out_y)
                    report_mismatch("force_out_y", o_out.force_out_y, want.force_out_y);
                if (o_out.force_out_z !== want.force_out_z)
                    report_mismatch("force_out_z", o_out.force_out_z, want.force_out_z);
                if (o_out.torque_out_x !== want.torque_out_x)
                    report_mismatch("torque_out_x", o_out.torque_out_x, want.torque_out_x);
                if (o_out.torque_out_y !== want.torque_out_y)
                    report_mismatch("torque_out_y", o_out.torque_out_y, want.torque_out_y);
                if (o_out.torque_out_z !== want.torque_out_z)
                    report_mismatch("torque_out_z", o_out.torque_out_z, want.torque_out_z);
            end
        end
    end

    task automatic send_command(input uvwc_pkg::t_in c);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        wrench_queue.push_back(compensate_wrench(c));
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [uvwc_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [uvwc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            uvwc_pkg::REG_VEHICLE_MASS:    vehicle_cfg.vehicle_mass = data[31:0];
            uvwc_pkg::REG_BUOYANCY_FORCE:  vehicle_cfg.buoyancy_force = data[31:0];
            uvwc_pkg::REG_GRAVITY_CENTRE:  vehicle_cfg.gravity_centre = data;
            uvwc_pkg::REG_BUOYANCY_CENTRE: vehicle_cfg.buoyancy_centre = data;
            uvwc_pkg::REG_LIN_DRAG_TRANS:  vehicle_cfg.linear_drag_translation = data;
            uvwc_pkg::REG_LIN_DRAG_ROT:    vehicle_cfg.linear_drag_rotation = data;
            uvwc_pkg::REG_QUAD_DRAG_TRANS: vehicle_cfg.quadratic_drag_translation = data;
            uvwc_pkg::REG_QUAD_DRAG_ROT:   vehicle_cfg.quadratic_drag_rotation = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (wrench_queue.size() != 0 && guard < 10000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [15:0] q14_unit_lane();
        int v;
        v = $urandom_range(32768) - 16384;
        return 16'(v);
    endfunction

    function automatic uvwc_pkg::t_in random_command(input bit unit_attitude);
        uvwc_pkg::t_in c;
        c.force_in_x  = $urandom;
        c.force_in_y  = $urandom;
        c.force_in_z  = $urandom;
        c.torque_in_x = $urandom;
        c.torque_in_y = $urandom;
        c.torque_in_z = $urandom;
        if (unit_attitude)
            c.attitude = {q14_unit_lane(), q14_unit_lane(), q14_unit_lane(), q14_unit_lane()};
        else
            c.attitude = {$urandom, $urandom};
        c.linear_velocity  = rand48();
        c.angular_velocity = rand48();
        c.water_current    = rand48();
        if ($urandom_range(3) == 0) begin
            c.linear_velocity  = {3{16'(int'($urandom_range(512)) - 256)}};
            c.angular_velocity = {3{16'(int'($urandom_range(512)) - 256)}};
        end
        return c;
    endfunction

    task automatic write_all_registers(input int mode);
        logic [47:0] d;
        for (int r = uvwc_pkg::REG_VEHICLE_MASS; r <= uvwc_pkg::REG_QUAD_DRAG_ROT; r++) begin
            case (mode)
                0: d = '0;
                1: d = '1;
                2: d = (r == uvwc_pkg::REG_BUOYANCY_FORCE) ? 48'h0000_8000_0000
                                                           : 48'h7FFF_7FFF_7FFF;
                default: d = rand48() & ((r >= uvwc_pkg::REG_LIN_DRAG_TRANS)
                                         ? 48'h03FF_03FF_03FF : '1);
            endcase
            write_register((uvwc_pkg::CFG_INDEX_W)'(r), d);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        uvwc_pkg::t_in c;
        write_all_registers(3);
        for (int n = 0; n < 20; n++) begin
            c = '0;
            case (n % 5)
                0: c = '0;
                1: c = '1;
                2: c = {{6{32'h7FFF_FFFF}}, 64'h7FFF_7FFF_7FFF_7FFF, {3{48'h7FFF_7FFF_7FFF}}};
                3: c = {{6{32'h8000_0000}}, 64'h8000_8000_8000_8000, {3{48'h8000_8000_8000}}};
                default: c = random_command(n < 10);
            endcase
            if (n >= 10)
                c.attitude = (n < 15) ? 64'h0000_0000_0000_4000 : 64'h4000_0000_0000_0000;
            send_command(c);
        end
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        for (int mode = 0; mode < 3; mode++) begin
            write_all_registers(mode);
            for (int n = 0; n < 8; n++) send_command(random_command(n[0]));
            drain_pipeline();
        end
        write_register((uvwc_pkg::CFG_INDEX_W)'(12), '1);
        i_cfg_valid <= 1'b0;
        send_command(random_command(1'b1));
        drain_pipeline();
    endtask

    task automatic test_random_traffic(input int sender_gap, input int count);
        gap_pct = sender_gap;
        write_all_registers(3);
        for (int n = 0; n < count; n++) begin
            if (n % 120 == 119) begin
                drain_pipeline();
                write_all_registers(3);
            end
            send_command(random_command($urandom_range(9) != 0));
        end
        drain_pipeline();
    endtask

    initial begin
        mismatch_count = 0;
        gap_pct        = 0;
        vehicle_cfg    = '0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_in           = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_extremes();
        test_register_extremes();
        test_random_traffic(23, 360);
        test_random_traffic(56, 360);
        test_random_traffic(0, 360);
        if (mismatch_count == 0 && wrench_queue.size() == 0) begin
            $display("underwater_vehicle_wrench_compensation_tb: PASS");
        end else begin
            $display("underwater_vehicle_wrench_compensation_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/uvwc_pkg.sv
design/uvwc_cfg_regs.sv
design/underwater_vehicle_wrench_compensation.sv
verif/underwater_vehicle_wrench_compensation_tb.sv
